### design/xmt_pkg.sv
// Package for the XML markup tokenizer: item types, character-class bundle,
// parse phase, token kind and status codes. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package xmt_pkg;

  // Input item: one document byte and its last-byte flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  // Result item: token kind, token start flag and status.
  typedef struct packed {
    logic [2:0] token_kind;
    logic       token_start;
    logic [2:0] status;
  } out_item_t;

  // Classified byte, as handed from the front end to the parser.
  typedef struct packed {
    logic ws;
    logic name_start;
    logic name_char;
    logic lt;
    logic gt;
    logic slash;
    logic eq;
    logic quote;
    logic last;
  } char_class_t;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_TEXT        = 4'd1,
    PH_AFTER_OPEN  = 4'd2,
    PH_TAGNAME     = 4'd3,
    PH_AFTER_TAG   = 4'd4,
    PH_ATTRNAME    = 4'd5,
    PH_AFTER_ATTR  = 4'd6,
    PH_AFTER_EQ    = 4'd7,
    PH_VALUE_OPEN  = 4'd8,
    PH_VALUE       = 4'd9,
    PH_AFTER_SLASH = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    K_SKIP  = 3'd0,
    K_OPEN  = 3'd1,
    K_TAG   = 3'd2,
    K_ATTR  = 3'd3,
    K_VALUE = 3'd4,
    K_TEXT  = 3'd5,
    K_SLASH = 3'd6,
    K_CLOSE = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_END   = 3'd1,
    ST_CHAR  = 3'd2,
    ST_QUOTE = 3'd3,
    ST_EOF   = 3'd4
  } status_e;

  localparam logic [7:0] CHAR_LT    = 8'h3C; // '<'
  localparam logic [7:0] CHAR_GT    = 8'h3E; // '>'
  localparam logic [7:0] CHAR_SLASH = 8'h2F; // '/'
  localparam logic [7:0] CHAR_EQ    = 8'h3D; // '='
  localparam logic [7:0] CHAR_QUOTE = 8'h22; // '"'

  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

### design/xmt_front.sv
// Front end of the tokenizer: takes input items and sorts each byte into
// character classes. Depends on xmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xmt_front (
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire xmt_pkg::in_item_t in_data_i,
  output logic                  push_o,
  input  wire logic             full_i,
  output xmt_pkg::char_class_t  class_o
);

  logic [7:0] c;
  logic       alpha;

  assign c     = in_data_i.in_byte;
  assign alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);

  always_comb begin
    class_o.ws         = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    class_o.name_start = alpha || (c == 8'h5F) || (c == 8'h3A);
    class_o.name_char  = alpha || (c == 8'h5F) || (c == 8'h3A)
                         || (c >= 8'h30 && c <= 8'h39) || (c == 8'h2D) || (c == 8'h2E);
    class_o.lt         = (c == xmt_pkg::CHAR_LT);
    class_o.gt         = (c == xmt_pkg::CHAR_GT);
    class_o.slash      = (c == xmt_pkg::CHAR_SLASH);
    class_o.eq         = (c == xmt_pkg::CHAR_EQ);
    class_o.quote      = (c == xmt_pkg::CHAR_QUOTE);
    class_o.last       = in_data_i.is_last;
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

`default_nettype wire

### design/xmt_queue.sv
// Short queue of classified bytes between front end and parser.
// Depends on xmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xmt_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire xmt_pkg::char_class_t wdata_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output xmt_pkg::char_class_t     rdata_o
);

  localparam int unsigned PtrW = $clog2(xmt_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(xmt_pkg::QUEUE_DEPTH + 1);

  xmt_pkg::char_class_t mem_q [xmt_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(xmt_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(xmt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(xmt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### design/xmt_back.sv
// Back end of the tokenizer: parse phase machine over classified bytes and
// the registered result stage. Depends on xmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xmt_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 empty_i,
  input  wire xmt_pkg::char_class_t cls_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output xmt_pkg::out_item_t        out_data_o
);

  xmt_pkg::phase_e    phase_q, phase_d, nx_phase;
  logic               halted_q, halted_d;
  logic               out_valid_q, out_valid_d;
  xmt_pkg::out_item_t out_q, res;
  xmt_pkg::kind_e     kind;
  logic               start;
  xmt_pkg::status_e   err;

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  // Byte decoder: kind, start flag, phase to go to, or an error code.
  always_comb begin
    nx_phase = phase_q;
    kind     = xmt_pkg::K_SKIP;
    start    = 1'b0;
    err      = xmt_pkg::ST_OK;
    unique case (phase_q)
      xmt_pkg::PH_TEXT: begin
        if (cls_i.lt) begin
          kind = xmt_pkg::K_OPEN; start = 1'b1; nx_phase = xmt_pkg::PH_AFTER_OPEN;
        end else begin
          kind = xmt_pkg::K_TEXT;
        end
      end
      xmt_pkg::PH_AFTER_OPEN: begin
        if (cls_i.ws) begin
          kind = xmt_pkg::K_SKIP;
        end else if (cls_i.name_start) begin
          kind = xmt_pkg::K_TAG; start = 1'b1; nx_phase = xmt_pkg::PH_TAGNAME;
        end else if (cls_i.slash) begin
          kind = xmt_pkg::K_SLASH; start = 1'b1; nx_phase = xmt_pkg::PH_AFTER_SLASH;
        end else begin
          err = xmt_pkg::ST_CHAR;
        end
      end
      xmt_pkg::PH_TAGNAME, xmt_pkg::PH_AFTER_TAG: begin
        if (phase_q == xmt_pkg::PH_TAGNAME && cls_i.name_char) begin
          kind = xmt_pkg::K_TAG;
        end else if (cls_i.ws) begin
          kind = xmt_pkg::K_SKIP; nx_phase = xmt_pkg::PH_AFTER_TAG;
        end else if (cls_i.gt) begin
          kind = xmt_pkg::K_CLOSE; start = 1'b1; nx_phase = xmt_pkg::PH_IDLE;
        end else if (cls_i.slash) begin
          kind = xmt_pkg::K_SLASH; start = 1'b1; nx_phase = xmt_pkg::PH_AFTER_SLASH;
        end else if (cls_i.name_start) begin
          kind = xmt_pkg::K_ATTR; start = 1'b1; nx_phase = xmt_pkg::PH_ATTRNAME;
        end else begin
          err = xmt_pkg::ST_CHAR;
        end
      end
      xmt_pkg::PH_ATTRNAME, xmt_pkg::PH_AFTER_ATTR: begin
        if (phase_q == xmt_pkg::PH_ATTRNAME && cls_i.name_char) begin
          kind = xmt_pkg::K_ATTR;
        end else if (cls_i.ws) begin
          kind = xmt_pkg::K_SKIP; nx_phase = xmt_pkg::PH_AFTER_ATTR;
        end else if (cls_i.gt) begin
          kind = xmt_pkg::K_CLOSE; start = 1'b1; nx_phase = xmt_pkg::PH_IDLE;
        end else if (cls_i.eq) begin
          kind = xmt_pkg::K_SKIP; nx_phase = xmt_pkg::PH_AFTER_EQ;
        end else if (cls_i.slash) begin
          kind = xmt_pkg::K_SLASH; start = 1'b1; nx_phase = xmt_pkg::PH_AFTER_SLASH;
        end else if (cls_i.name_start) begin
          kind = xmt_pkg::K_ATTR; start = 1'b1; nx_phase = xmt_pkg::PH_ATTRNAME;
        end else begin
          err = xmt_pkg::ST_CHAR;
        end
      end
      xmt_pkg::PH_AFTER_EQ: begin
        if (cls_i.ws) begin
          kind = xmt_pkg::K_SKIP;
        end else if (cls_i.quote) begin
          kind = xmt_pkg::K_SKIP; nx_phase = xmt_pkg::PH_VALUE_OPEN;
        end else begin
          err = xmt_pkg::ST_QUOTE;
        end
      end
      xmt_pkg::PH_VALUE_OPEN, xmt_pkg::PH_VALUE: begin
        if (cls_i.quote) begin
          kind = xmt_pkg::K_SKIP; nx_phase = xmt_pkg::PH_AFTER_TAG;
        end else begin
          kind     = xmt_pkg::K_VALUE;
          start    = (phase_q == xmt_pkg::PH_VALUE_OPEN);
          nx_phase = xmt_pkg::PH_VALUE;
        end
      end
      xmt_pkg::PH_AFTER_SLASH: begin
        if (cls_i.ws) begin
          kind = xmt_pkg::K_SKIP;
        end else if (cls_i.name_start) begin
          kind = xmt_pkg::K_TAG; start = 1'b1; nx_phase = xmt_pkg::PH_TAGNAME;
        end else if (cls_i.gt) begin
          kind = xmt_pkg::K_CLOSE; start = 1'b1; nx_phase = xmt_pkg::PH_IDLE;
        end else begin
          err = xmt_pkg::ST_CHAR;
        end
      end
      default: begin
        // between elements; unused codes behave the same
        if (cls_i.ws) begin
          kind = xmt_pkg::K_SKIP; nx_phase = xmt_pkg::PH_IDLE;
        end else if (cls_i.lt) begin
          kind = xmt_pkg::K_OPEN; start = 1'b1; nx_phase = xmt_pkg::PH_AFTER_OPEN;
        end else begin
          kind = xmt_pkg::K_TEXT; start = 1'b1; nx_phase = xmt_pkg::PH_TEXT;
        end
      end
    endcase
  end

  // Next state
  always_comb begin
    phase_d  = phase_q;
    halted_d = halted_q;
    if (pop_o && !halted_q) begin
      if (err != xmt_pkg::ST_OK) begin
        halted_d = 1'b1;
      end else if (cls_i.last) begin
        if (nx_phase == xmt_pkg::PH_IDLE) begin
          phase_d = xmt_pkg::PH_IDLE;
        end else begin
          halted_d = 1'b1;
        end
      end else begin
        phase_d = nx_phase;
      end
    end
  end

  // Result of the byte being popped
  always_comb begin
    res.token_kind  = kind;
    res.token_start = start;
    res.status      = xmt_pkg::ST_OK;
    if (halted_q) begin
      res.token_kind  = xmt_pkg::K_SKIP;
      res.token_start = 1'b0;
    end else if (err != xmt_pkg::ST_OK) begin
      res.token_kind  = xmt_pkg::K_SKIP;
      res.token_start = 1'b0;
      res.status      = err;
    end else if (cls_i.last) begin
      res.status = (nx_phase == xmt_pkg::PH_IDLE) ? xmt_pkg::ST_END : xmt_pkg::ST_EOF;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= xmt_pkg::PH_IDLE;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt released without reset");

  a_halted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && halted_q) |=> (out_q.token_kind == xmt_pkg::K_SKIP
      && !out_q.token_start && out_q.status == xmt_pkg::ST_OK))
    else $error("halted byte gave a non-zero result");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !halted_q && (res.status == xmt_pkg::ST_CHAR
      || res.status == xmt_pkg::ST_QUOTE || res.status == xmt_pkg::ST_EOF)) |=> halted_q)
    else $error("error status without halt");

  a_pop_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped byte produced no result");
`endif

endmodule

`default_nettype wire

### design/xml_markup_tokenizer_unit.sv
// XML markup tokenizer top level: front end, queue, parser back end.
// Depends on xmt_pkg, xmt_front, xmt_queue and xmt_back.
// Throughput: one byte per cycle while the output is taken, set by the phase machine.
// Path: an accepted byte passes through the queue and then the result register.
// Reset: asynchronous, active low; phase goes to between elements, halt clears,
// queue and result register empty.
`timescale 1ns / 1ps
`default_nettype none

module xml_markup_tokenizer_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire xmt_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output xmt_pkg::out_item_t      out_data_o
);

  // Classified byte heading into the queue, and the one at its head.
  xmt_pkg::char_class_t push_cls;
  xmt_pkg::char_class_t head_cls;
  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;

  // Front end: ready whenever the queue has room, so an item is taken even
  // while a finished result still waits at the output.
  xmt_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .full_i     (full),
    .class_o    (push_cls)
  );

  // Two-entry queue: push and pop in the same cycle keep full rate.
  xmt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cls),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head_cls)
  );

  // Parser: one byte per cycle into the result register, popping whenever
  // the register is free or being emptied this cycle.
  xmt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cls_i       (head_cls),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
